// ===== hdl/arm_multiply_accumulate_unit_assert.svh =====
// Assertion macros for the ARM multiply-accumulate unit.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef ARM_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH
`define ARM_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define MAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next one.
`define MAU_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/mau_pkg.sv =====
// Shared types and constants of the multiply-accumulate unit.
// No dependencies.
`timescale 1ns / 1ps

package mau_pkg;

    localparam int HALF_BITS = 16;

    typedef enum logic [4:0] {
        OP_MUL, OP_MLA, OP_MLS, OP_UMULL, OP_UMLAL, OP_UMAAL, OP_SMULL, OP_SMLAL,
        OP_SMULXY, OP_SMLAXY, OP_SMLALXY, OP_SMULWY, OP_SMLAWY, OP_SMMUL, OP_SMMLA,
        OP_SMMLS, OP_SMUAD, OP_SMLAD, OP_SMUSD, OP_SMLSD, OP_SMLALD, OP_SMLSLD
    } t_op;

    // How stage two forms the product term
    typedef enum logic [1:0] {
        MS_PROD, MS_WY, MS_DSUM, MS_DDIFF
    } t_msel;

    // Classified item, front to back
    typedef struct packed {
        logic        exec;
        logic        long_f;
        logic        flag_f;
        logic        q_f;
        logic        msw;
        logic        neg;
        t_msel       msel;
        logic [32:0] ma;
        logic [32:0] mb;
        logic [15:0] nlo;
        logic [15:0] nhi;
        logic [15:0] mlo;
        logic [15:0] mhi;
        logic [63:0] acc;
    } t_dec;

    // Finished result
    typedef struct packed {
        logic        executed;
        logic [31:0] res_lo;
        logic [31:0] res_hi;
        logic        writes_hi;
        logic        flags_valid;
        logic        n_flag;
        logic        z_flag;
        logic        q_overflow;
    } t_res;

endpackage

// ===== hdl/mau_fifo.sv =====
// Small register-based queue with occupancy count.
// No dependencies.
`timescale 1ns / 1ps

module mau_fifo #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [P_WIDTH-1:0]               i_data,
    output logic                             o_full,
    input  logic                             i_pop,
    output logic [P_WIDTH-1:0]               o_data,
    output logic                             o_empty,
    output logic [$clog2(P_DEPTH+1)-1:0]     o_count
);
    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH+1);
    localparam logic [AW-1:0] LAST = AW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [AW-1:0]      r_wp, r_rp;
    logic [CW-1:0]      r_cnt;
    logic               wr, rd;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            if (wr && !rd) r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== hdl/mau_front.sv =====
// Front end: classifies one multiply instruction into operand selects.
// Depends on mau_pkg.
`timescale 1ns / 1ps

module mau_front import mau_pkg::*; (
    input  logic [4:0]  i_req_type,
    input  logic [31:0] i_op_n,
    input  logic [31:0] i_op_m,
    input  logic [31:0] i_op_a,
    input  logic [31:0] i_op_hi,
    input  logic        i_n_top,
    input  logic        i_m_top,
    input  logic        i_round,
    input  logic        i_set_flags,
    input  logic        i_cond_passed,
    output t_dec        o_dec
);
    logic [15:0] hn, hm;
    logic [63:0] acc64, sxa, rnd_lo, rnd_hi;
    logic        valid, flag;

    assign hn     = i_n_top ? i_op_n[31:16] : i_op_n[15:0];
    assign hm     = i_m_top ? i_op_m[31:16] : i_op_m[15:0];
    assign acc64  = {i_op_hi, i_op_a};
    assign sxa    = {{32{i_op_a[31]}}, i_op_a};
    assign rnd_lo = {32'b0, i_round, 31'b0};
    assign rnd_hi = {i_op_a, i_round, 31'b0};

    always_comb begin
        o_dec        = '0;
        valid        = 1'b1;
        flag         = 1'b0;
        o_dec.msel   = MS_PROD;
        o_dec.ma     = {1'b0, i_op_n};
        o_dec.mb     = {1'b0, i_op_m};
        o_dec.nlo    = i_op_n[15:0];
        o_dec.nhi    = i_op_n[31:16];
        o_dec.mlo    = i_m_top ? i_op_m[31:16] : i_op_m[15:0];
        o_dec.mhi    = i_m_top ? i_op_m[15:0] : i_op_m[31:16];
        case (t_op'(i_req_type))
            OP_MUL:   flag = 1'b1;
            OP_MLA: begin flag = 1'b1; o_dec.acc = {32'b0, i_op_a}; end
            OP_MLS: begin o_dec.neg = 1'b1; o_dec.acc = {32'b0, i_op_a}; end
            OP_UMULL: begin o_dec.long_f = 1'b1; flag = 1'b1; end
            OP_UMLAL: begin o_dec.long_f = 1'b1; flag = 1'b1; o_dec.acc = acc64; end
            OP_UMAAL: begin
                o_dec.long_f = 1'b1;
                o_dec.acc    = 64'(i_op_hi) + 64'(i_op_a);
            end
            OP_SMULL, OP_SMLAL: begin
                o_dec.long_f = 1'b1;
                flag         = 1'b1;
                o_dec.ma     = {i_op_n[31], i_op_n};
                o_dec.mb     = {i_op_m[31], i_op_m};
                if (t_op'(i_req_type) == OP_SMLAL) o_dec.acc = acc64;
            end
            OP_SMULXY, OP_SMLAXY, OP_SMLALXY: begin
                o_dec.ma = 33'($signed(hn));
                o_dec.mb = 33'($signed(hm));
                if (t_op'(i_req_type) == OP_SMLAXY) begin
                    o_dec.acc = sxa;
                    o_dec.q_f = 1'b1;
                end else if (t_op'(i_req_type) == OP_SMLALXY) begin
                    o_dec.acc    = acc64;
                    o_dec.long_f = 1'b1;
                end
            end
            OP_SMULWY, OP_SMLAWY: begin
                o_dec.msel = MS_WY;
                o_dec.ma   = {i_op_n[31], i_op_n};
                o_dec.mb   = 33'($signed(hm));
                if (t_op'(i_req_type) == OP_SMLAWY) begin
                    o_dec.acc = sxa;
                    o_dec.q_f = 1'b1;
                end
            end
            OP_SMMUL, OP_SMMLA, OP_SMMLS: begin
                o_dec.msw = 1'b1;
                o_dec.ma  = {i_op_n[31], i_op_n};
                o_dec.mb  = {i_op_m[31], i_op_m};
                o_dec.acc = (t_op'(i_req_type) == OP_SMMUL) ? rnd_lo : rnd_hi;
                o_dec.neg = (t_op'(i_req_type) == OP_SMMLS);
            end
            OP_SMUAD:  begin o_dec.msel = MS_DSUM; o_dec.q_f = 1'b1; end
            OP_SMLAD:  begin o_dec.msel = MS_DSUM; o_dec.q_f = 1'b1; o_dec.acc = sxa; end
            OP_SMUSD:  o_dec.msel = MS_DDIFF;
            OP_SMLSD:  begin o_dec.msel = MS_DDIFF; o_dec.q_f = 1'b1; o_dec.acc = sxa; end
            OP_SMLALD: begin o_dec.msel = MS_DSUM; o_dec.long_f = 1'b1; o_dec.acc = acc64; end
            OP_SMLSLD: begin o_dec.msel = MS_DDIFF; o_dec.long_f = 1'b1; o_dec.acc = acc64; end
            default: valid = 1'b0;
        endcase
        o_dec.exec   = valid && i_cond_passed;
        o_dec.flag_f = flag && i_set_flags;
    end

endmodule

// ===== hdl/mau_back.sv =====
// Back end: three-stage multiply / combine / accumulate pipeline with
// credit check against the result queue. Depends on mau_pkg and the assert header.
`timescale 1ns / 1ps
`include "arm_multiply_accumulate_unit_assert.svh"

module mau_back import mau_pkg::*; #(
    parameter int P_OUT_DEPTH = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_mid_empty,
    input  t_dec                               i_dec,
    output logic                               o_mid_pop,
    input  logic [$clog2(P_OUT_DEPTH+1)-1:0]   i_out_count,
    output logic                               o_out_push,
    output t_res                               o_res
);
    localparam int CW = $clog2(P_OUT_DEPTH+1);
    localparam logic [CW:0] DEPTH_C = (CW+1)'(P_OUT_DEPTH);

    logic        r_v1, r_v2, r_v3;
    t_dec        r_d1, r_d2, r_d3;
    logic [65:0] r_prod;
    logic [31:0] r_p1, r_p2;
    logic [63:0] r_x, r_r;
    logic [63:0] x;
    logic [CW:0] occ;
    logic        z64, z32, fits;

    // Items in flight plus results waiting must never exceed the queue
    assign occ = (CW+1)'(r_v1) + (CW+1)'(r_v2) + (CW+1)'(r_v3) + (CW+1)'(i_out_count);
    assign o_mid_pop  = !i_mid_empty && (occ < DEPTH_C);
    assign o_out_push = r_v3;

    always_comb begin
        case (r_d1.msel)
            MS_PROD:  x = r_prod[63:0];
            MS_WY:    x = {{32{r_prod[47]}}, r_prod[47:16]};
            MS_DSUM:  x = {{32{r_p1[31]}}, r_p1} + {{32{r_p2[31]}}, r_p2};
            MS_DDIFF: x = {{32{r_p1[31]}}, r_p1} - {{32{r_p2[31]}}, r_p2};
            default:  x = r_prod[63:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= o_mid_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1   <= i_dec;
        r_prod <= 66'($signed(i_dec.ma) * $signed(i_dec.mb));
        r_p1   <= 32'($signed(i_dec.nlo) * $signed(i_dec.mlo));
        r_p2   <= 32'($signed(i_dec.nhi) * $signed(i_dec.mhi));
        r_d2   <= r_d1;
        r_x    <= x;
        r_d3   <= r_d2;
        r_r    <= (r_d2.neg ? ~r_x : r_x) + r_d2.acc + 64'(r_d2.neg);
    end

    assign z64  = (r_r == '0);
    assign z32  = (r_r[31:0] == '0);
    assign fits = (r_r[63:31] == '0) || (r_r[63:31] == '1);

    always_comb begin
        o_res = '0;
        if (r_d3.exec) begin
            o_res.executed    = 1'b1;
            o_res.res_lo      = r_d3.msw ? r_r[63:32] : r_r[31:0];
            o_res.res_hi      = r_d3.long_f ? r_r[63:32] : 32'b0;
            o_res.writes_hi   = r_d3.long_f;
            o_res.flags_valid = r_d3.flag_f;
            o_res.n_flag      = r_d3.flag_f && (r_d3.long_f ? r_r[63] : r_r[31]);
            o_res.z_flag      = r_d3.flag_f && (r_d3.long_f ? z64 : z32);
            o_res.q_overflow  = r_d3.q_f && !fits;
        end
    end

    `MAU_ASSERT(a_credit, occ <= DEPTH_C, "pipeline occupancy above result queue depth")
    `MAU_ASSERT(a_room, !r_v3 || (i_out_count < CW'(P_OUT_DEPTH)), "result pushed into full queue")
    `MAU_ASSERT_NEXT(a_flow, r_v1 && r_v2, r_v2 && r_v3, "pipeline lost an item")

endmodule

// ===== hdl/arm_multiply_accumulate_unit.sv =====
// Each input goes through the mid queue and the pipeline to the output queue.
// One instruction per cycle through the 3-stage multiply pipeline, while credit allows.
// The result queue holds P_OUT_DEPTH results; the back end issues only while a slot
// is reserved for every item in flight, so a stalled consumer stops intake cleanly.
// Reset: synchronous active-low i_rst_n empties both queues and the pipeline.
`timescale 1ns / 1ps

module arm_multiply_accumulate_unit import mau_pkg::*; #(
    parameter int P_MID_DEPTH = 2,
    parameter int P_OUT_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [4:0]  i_req_type,
    input  logic [31:0] i_op_n,
    input  logic [31:0] i_op_m,
    input  logic [31:0] i_op_a,
    input  logic [31:0] i_op_hi,
    input  logic        i_n_top,
    input  logic        i_m_top,
    input  logic        i_round,
    input  logic        i_set_flags,
    input  logic        i_cond_passed,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        o_executed,
    output logic [31:0] o_res_lo,
    output logic [31:0] o_res_hi,
    output logic        o_writes_hi,
    output logic        o_flags_valid,
    output logic        o_n_flag,
    output logic        o_z_flag,
    output logic        o_q_overflow
);
    t_dec front_dec, mid_dec;
    t_res back_res, out_res;
    logic mid_empty, mid_pop, out_push, out_full;
    logic [$clog2(P_MID_DEPTH+1)-1:0] mid_count;
    logic [$clog2(P_OUT_DEPTH+1)-1:0] out_count;

    // Front: classify the instruction as it is transferred in
    mau_front u_front (
        .i_req_type    (i_req_type),
        .i_op_n        (i_op_n),
        .i_op_m        (i_op_m),
        .i_op_a        (i_op_a),
        .i_op_hi       (i_op_hi),
        .i_n_top       (i_n_top),
        .i_m_top       (i_m_top),
        .i_round       (i_round),
        .i_set_flags   (i_set_flags),
        .i_cond_passed (i_cond_passed),
        .o_dec         (front_dec)
    );

    // Short queue between front and back; its full flag is the input full
    mau_fifo #(.P_WIDTH($bits(t_dec)), .P_DEPTH(P_MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_dec),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_dec),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    // Back: multiply, combine, accumulate, flags
    mau_back #(.P_OUT_DEPTH(P_OUT_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_dec       (mid_dec),
        .o_mid_pop   (mid_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_res       (back_res)
    );

    // Result queue; results wait here while the consumer stalls
    mau_fifo #(.P_WIDTH($bits(t_res)), .P_DEPTH(P_OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_executed    = out_res.executed;
    assign o_res_lo      = out_res.res_lo;
    assign o_res_hi      = out_res.res_hi;
    assign o_writes_hi   = out_res.writes_hi;
    assign o_flags_valid = out_res.flags_valid;
    assign o_n_flag      = out_res.n_flag;
    assign o_z_flag      = out_res.z_flag;
    assign o_q_overflow  = out_res.q_overflow;

    // Credit scheme means the back end never transfers into a full result queue
    `MAU_ASSERT(a_no_overrun, !(out_push && out_full), "result queue overrun")
    `MAU_ASSERT_NEXT(a_mid_bound, mid_pop && !push, mid_count < P_MID_DEPTH,
        "mid queue count wrong after pop")
    `MAU_ASSERT(a_out_cnt, empty == (out_count == '0), "result queue count and empty disagree")

endmodule
